// ===== design/stack_line_hex_address_parser_unit_macros.svh =====
// Assertion helpers for the stack-line parser.
`ifndef STACK_LINE_HEX_ADDRESS_PARSER_UNIT_MACROS_SVH
`define STACK_LINE_HEX_ADDRESS_PARSER_UNIT_MACROS_SVH

// Property sampled on clk, ignored while reset is asserted.
`define SLHAP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge.
`define SLHAP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== design/slhap_pkg.sv =====
package slhap_pkg;

	localparam int ADDR_W       = 64;
	localparam int CNT_W        = 5;
	localparam int MAX_DIGITS_D = 16;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	// Returns {is_hex, value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - 8'h57;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h37;
				hex_digit = {1'b1, d[3:0]};
			end else begin
				hex_digit = 5'b0_0000;
			end
		end
	endfunction

endpackage

// ===== design/stack_line_hex_address_parser_unit.sv =====
// Stack-line hex address parser.
// Input channel s_*: one text character per word in s_tdata[7:0]; s_tlast
// marks the line terminator word (its character is ignored).
// Output channel m_*: m_tdata is the 64-bit address, m_tuser[0] says the
// word carries an address, m_tuser[1] marks the first address of a line,
// m_tlast closes the line. Every terminator gives exactly one output word;
// other characters give zero or one.
// Lines starting with '@' are parsed for space-separated hex tokens with an
// optional 0x/0X prefix; later addresses on a line are reported minus one.
// The input word passes through the input register, then one combinational
// parse step into the output register. Throughput: one character per cycle
// while the receiver takes the output words, set by the update of the parse
// state.
// Reset clears the input and output registers and puts the parser at line
// start. When the receiver stalls, the output word holds and the input
// register keeps one more character; s_tready then drops until the output
// word is taken.
`include "stack_line_hex_address_parser_unit_macros.svh"

module stack_line_hex_address_parser_unit #(
	parameter int MAX_DIGITS = slhap_pkg::MAX_DIGITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tlast,   // end_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] address
	output logic [1:0]  m_tuser,   // [0] address_valid, [1] first_in_line
	output logic        m_tlast    // line_done
);

	typedef enum logic [2:0] {
		PH_LINE, PH_IGNORE, PH_START, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_HELD
	} phase_t;

	localparam int AW = slhap_pkg::ADDR_W;
	localparam int CW = slhap_pkg::CNT_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_DIGITS);
	localparam bit FULL_ONE = (MAX_DIGITS == 1);

	// input register
	logic         vld_s1;
	logic [7:0]   chr_s1;
	logic         eol_s1;

	// parse state
	phase_t       phase_q;
	logic [AW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic         first_q;

	// output register
	logic          m_tvalid_q;
	logic [AW-1:0] addr_q;
	logic          addr_vld_q;
	logic          first_out_q;
	logic          done_q;

	logic out_free, adv;
	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;

	// next-state and result logic
	logic [4:0]    hx;
	logic [3:0]    hv;
	logic          hok, tk_digit;
	phase_t        tk_phase;
	logic [AW-1:0] base_acc, db_acc;
	logic [CW-1:0] base_cnt, db_cnt;
	logic          db_full;
	phase_t        nxt_phase;
	logic [AW-1:0] nxt_acc;
	logic [CW-1:0] nxt_cnt;
	logic          nxt_first;
	logic          emit, produce;
	logic [AW-1:0] emit_val, out_addr;

	always_comb begin
		hx  = slhap_pkg::hex_digit(chr_s1);
		hv  = hx[3:0];
		hok = hx[4];

		// outcome of a character at token start
		tk_digit = hok && (chr_s1 != slhap_pkg::CH_ZERO);
		if (chr_s1 == slhap_pkg::CH_SPACE) begin
			tk_phase = PH_START;
		end else if (chr_s1 == slhap_pkg::CH_ZERO) begin
			tk_phase = PH_ZERO;
		end else if (!hok) begin
			tk_phase = PH_IGNORE;
		end else if (FULL_ONE) begin
			tk_phase = PH_START;
		end else begin
			tk_phase = PH_DIGITS;
		end

		// digit inside a token; base depends on how the token began
		base_acc = (phase_q == PH_DIGITS) ? acc_q : '0;
		if (phase_q == PH_DIGITS) begin
			base_cnt = cnt_q;
		end else if (phase_q == PH_ZERO) begin
			base_cnt = CW'(1);
		end else begin
			base_cnt = '0;
		end
		db_acc  = {base_acc[AW-5:0], hv};
		db_cnt  = base_cnt + CW'(1);
		db_full = (db_cnt >= MAX_C);

		nxt_phase = phase_q;
		nxt_acc   = acc_q;
		nxt_cnt   = cnt_q;
		nxt_first = first_q;
		emit      = 1'b0;
		emit_val  = acc_q;

		if (eol_s1) begin
			if (phase_q == PH_DIGITS || phase_q == PH_HELD) begin
				emit = 1'b1;
			end else if (phase_q == PH_ZERO) begin
				emit     = 1'b1;
				emit_val = '0;
			end
			nxt_phase = PH_LINE;
			nxt_acc   = '0;
			nxt_cnt   = '0;
			nxt_first = 1'b1;
		end else begin
			unique case (phase_q)
				PH_LINE: begin
					nxt_phase = (chr_s1 == slhap_pkg::CH_AT) ? PH_START : PH_IGNORE;
					nxt_first = 1'b1;
				end
				PH_START: begin
					nxt_phase = tk_phase;
					if (tk_digit) begin
						nxt_acc = AW'(hv);
						nxt_cnt = CW'(1);
						if (FULL_ONE) begin
							emit     = 1'b1;
							emit_val = AW'(hv);
						end
					end
				end
				PH_ZERO, PH_PREFIX, PH_DIGITS: begin
					if (phase_q == PH_ZERO &&
					    (chr_s1 == slhap_pkg::CH_LX || chr_s1 == slhap_pkg::CH_UX)) begin
						nxt_acc   = '0;
						nxt_cnt   = '0;
						nxt_phase = PH_PREFIX;
					end else if (phase_q == PH_ZERO && FULL_ONE) begin
						// lone zero is a full token; a following nonzero digit is held
						emit      = 1'b1;
						emit_val  = '0;
						nxt_acc   = '0;
						nxt_cnt   = CW'(1);
						nxt_phase = tk_phase;
						if (tk_digit) begin
							nxt_acc   = AW'(hv);
							nxt_phase = PH_HELD;
						end
					end else if (phase_q == PH_PREFIX && !hok) begin
						nxt_phase = PH_IGNORE;
					end else if (!hok) begin
						emit      = 1'b1;
						emit_val  = base_acc;
						nxt_acc   = base_acc;
						nxt_cnt   = base_cnt;
						nxt_phase = (chr_s1 == slhap_pkg::CH_SPACE) ? PH_START : PH_IGNORE;
					end else begin
						nxt_acc   = db_acc;
						nxt_cnt   = db_cnt;
						nxt_phase = PH_DIGITS;
						if (db_full) begin
							emit      = 1'b1;
							emit_val  = db_acc;
							nxt_phase = PH_START;
						end
					end
				end
				PH_HELD: begin
					emit      = 1'b1;
					emit_val  = acc_q;
					nxt_phase = tk_phase;
					if (tk_digit) begin
						nxt_acc   = AW'(hv);
						nxt_cnt   = CW'(1);
						if (FULL_ONE) begin
							nxt_phase = PH_HELD;
						end
					end
				end
				default: begin
					nxt_phase = PH_IGNORE;
				end
			endcase
		end

		if (emit) begin
			nxt_first = eol_s1;
		end
		out_addr = first_q ? emit_val : emit_val - AW'(1);
		produce  = emit || eol_s1;
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			chr_s1      <= '0;
			eol_s1      <= 1'b0;
			phase_q     <= PH_LINE;
			acc_q       <= '0;
			cnt_q       <= '0;
			first_q     <= 1'b1;
			m_tvalid_q  <= 1'b0;
			addr_q      <= '0;
			addr_vld_q  <= 1'b0;
			first_out_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
				chr_s1 <= s_tdata;
				eol_s1 <= s_tlast;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end

			if (adv) begin
				phase_q <= nxt_phase;
				acc_q   <= nxt_acc;
				cnt_q   <= nxt_cnt;
				first_q <= nxt_first;
			end

			if (adv && produce) begin
				m_tvalid_q  <= 1'b1;
				addr_q      <= emit ? out_addr : '0;
				addr_vld_q  <= emit;
				first_out_q <= emit && first_q;
				done_q      <= eol_s1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = addr_q;
	assign m_tuser  = {first_out_q, addr_vld_q};
	assign m_tlast  = done_q;

	// checks
	`SLHAP_ASSERT(a_empty_word_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "empty word has data")
	`SLHAP_NEVER(a_first_needs_addr, m_tvalid && m_tuser[1] && !m_tuser[0], "first without address")
	`SLHAP_ASSERT(a_eol_resets, (adv && eol_s1) |=> (phase_q == PH_LINE && first_q), "no line restart")

endmodule

// ===== bench/stack_line_hex_address_parser_unit_test.sv =====
module stack_line_hex_address_parser_unit_test;

	localparam int MAX_DIGITS = slhap_pkg::MAX_DIGITS_D;
	localparam int RANDOM_WORDS = 1700;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;

	// Parser phases, mirrored in the tracker
	typedef enum logic [2:0] {
		LINE_START,
		LINE_SKIP,
		TOKEN_GAP,
		LEAD_ZERO,
		HEX_PREFIX,
		HEX_DIGITS,
		TOKEN_HELD
	} parse_phase_t;

	// One output word as the block should present it
	typedef struct {
		logic [63:0] address;
		logic        addr_valid;
		logic        first_in_line;
		logic        line_done;
	} addr_word_t;

	// Tracks the parser state and the queue of address words still owed
	class stack_addr_tracker;
		parse_phase_t phase;
		logic [63:0]  acc;
		int unsigned  ndig;
		bit           first_pending;
		addr_word_t   owed_words[$];
		int           mismatches;

		function new();
			mismatches = 0;
			clear_line();
		endfunction

		function void clear_line();
			phase = LINE_START;
			acc = '0;
			ndig = 0;
			first_pending = 1'b1;
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		function int hex_val(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - "0");
			if (c >= "a" && c <= "f") return int'(c - "a") + 10;
			if (c >= "A" && c <= "F") return int'(c - "A") + 10;
			return -1;
		endfunction

		// Later addresses on a line go out minus one, wrapping
		function void emit(logic [63:0] value, bit eol);
			addr_word_t w;
			w.address = first_pending ? value : value - 64'd1;
			w.addr_valid = 1'b1;
			w.first_in_line = first_pending;
			w.line_done = eol;
			owed_words.insert(owed_words.size(), w);
			first_pending = 1'b0;
		endfunction

		// First byte of a token; busy means a word already went out this step
		function void begin_token(logic [7:0] c, bit busy);
			int v;
			v = hex_val(c);
			if (c == slhap_pkg::CH_SPACE) begin
				phase = TOKEN_GAP;
			end else if (c == slhap_pkg::CH_ZERO) begin
				phase = LEAD_ZERO;
			end else if (v < 0) begin
				phase = LINE_SKIP;
			end else begin
				acc = 64'(v);
				ndig = 1;
				if (ndig >= MAX_DIGITS) begin
					if (busy) begin
						phase = TOKEN_HELD;
					end else begin
						emit(acc, 1'b0);
						phase = TOKEN_GAP;
					end
				end else begin
					phase = HEX_DIGITS;
				end
			end
		endfunction

		// Byte inside a token, after a leading zero, a prefix or a digit
		function void take_digit(logic [7:0] c);
			int v;
			v = hex_val(c);
			if (v < 0) begin
				emit(acc, 1'b0);
				phase = (c == slhap_pkg::CH_SPACE) ? TOKEN_GAP : LINE_SKIP;
			end else begin
				acc = {acc[59:0], 4'(v)};
				ndig = (ndig + 1) & 31;
				if (ndig >= MAX_DIGITS) begin
					emit(acc, 1'b0);
					phase = TOKEN_GAP;
				end
			end
		endfunction

		function void note_char(logic [7:0] c, bit eol);
			addr_word_t w;
			if (eol) begin
				if (phase == HEX_DIGITS || phase == TOKEN_HELD) begin
					emit(acc, 1'b1);
				end else if (phase == LEAD_ZERO) begin
					emit(64'd0, 1'b1);
				end else begin
					w.address = '0;
					w.addr_valid = 1'b0;
					w.first_in_line = 1'b0;
					w.line_done = 1'b1;
					owed_words.insert(owed_words.size(), w);
				end
				clear_line();
				return;
			end
			case (phase)
				LINE_START: begin
					phase = (c == slhap_pkg::CH_AT) ? TOKEN_GAP : LINE_SKIP;
					first_pending = 1'b1;
				end
				LINE_SKIP: ;
				TOKEN_GAP: begin
					begin_token(c, 1'b0);
				end
				LEAD_ZERO: begin
					acc = '0;
					if (c == slhap_pkg::CH_LX || c == slhap_pkg::CH_UX) begin
						ndig = 0;
						phase = HEX_PREFIX;
					end else begin
						ndig = 1;
						if (ndig >= MAX_DIGITS) begin
							emit(64'd0, 1'b0);
							begin_token(c, 1'b1);
						end else begin
							phase = HEX_DIGITS;
							take_digit(c);
						end
					end
				end
				HEX_PREFIX: begin
					if (hex_val(c) < 0) begin
						phase = LINE_SKIP;
					end else begin
						acc = '0;
						ndig = 0;
						phase = HEX_DIGITS;
						take_digit(c);
					end
				end
				HEX_DIGITS: begin
					take_digit(c);
				end
				TOKEN_HELD: begin
					emit(acc, 1'b0);
					begin_token(c, 1'b1);
				end
				default: phase = LINE_SKIP;
			endcase
		endfunction

		// Compare one accepted output word with the oldest owed word
		function void check_word(logic [63:0] address, logic addr_valid,
				logic first_in_line, logic line_done);
			addr_word_t w;
			if (owed_words.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: addr %h valid %b first %b done %b",
						address, addr_valid, first_in_line, line_done);
				mismatches++;
				return;
			end
			w = owed_words.pop_front();
			if (w.address !== address || w.addr_valid !== addr_valid ||
					w.first_in_line !== first_in_line || w.line_done !== line_done) begin
				if (mismatches < 10)
					$display("word mismatch: exp addr %h valid %b first %b done %b, got addr %h valid %b first %b done %b",
						w.address, w.addr_valid, w.first_in_line, w.line_done,
						address, addr_valid, first_in_line, line_done);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	stack_addr_tracker tracker = new();
	int words_sent = 0;
	bit no_idle = 1'b0;
	bit long_hold_req = 1'b0;

	stack_line_hex_address_parser_unit #(
		.MAX_DIGITS(MAX_DIGITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // [7:0] character
		.s_tlast(s_tlast),   // end_of_line
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),   // [63:0] address
		.m_tuser(m_tuser),   // [0] address_valid, [1] first_in_line
		.m_tlast(m_tlast)    // line_done
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop
	initial begin
		#(20 * 400000);
		$display("Mismatches found");
		$finish;
	end

	// Offer one word, wait for acceptance, then idle a random number of cycles
	task automatic send_word(input logic [7:0] c, input bit eol);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eol;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_char(c, eol);
		words_sent++;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return slhap_pkg::CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
	endfunction

	// Mostly well-formed stack lines, some noise and some broken lines
	task automatic send_random_line();
		logic [7:0] text[$];
		int kind, ntok, nsp, ndig, k;
		bit prev_full;
		kind = $urandom_range(0, 9);
		prev_full = 1'b0;
		if (kind == 0) begin
			repeat ($urandom_range(0, 12)) text.insert(text.size(), 8'($urandom_range(0, 255)));
		end else if (kind == 1) begin
			text.insert(text.size(), slhap_pkg::CH_AT);
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 4))
					0: text.insert(text.size(), slhap_pkg::CH_SPACE);
					1: text.insert(text.size(), slhap_pkg::CH_ZERO);
					2: text.insert(text.size(),
						$urandom_range(0, 1) ? slhap_pkg::CH_LX : slhap_pkg::CH_UX);
					3: text.insert(text.size(), rand_hex_char());
					default: text.insert(text.size(), 8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			text.insert(text.size(), slhap_pkg::CH_AT);
			ntok = $urandom_range(0, 6);
			for (k = 0; k < ntok; k++) begin
				// a full token may be followed directly by the next one
				nsp = $urandom_range((prev_full || k == 0) ? 0 : 1, 3);
				repeat (nsp) text.insert(text.size(), slhap_pkg::CH_SPACE);
				case ($urandom_range(0, 3))
					1: begin
						text.insert(text.size(), slhap_pkg::CH_ZERO);
						text.insert(text.size(), slhap_pkg::CH_LX);
					end
					2: begin
						text.insert(text.size(), slhap_pkg::CH_ZERO);
						text.insert(text.size(), slhap_pkg::CH_UX);
					end
					default: ;
				endcase
				ndig = ($urandom_range(0, 3) == 0) ? MAX_DIGITS : $urandom_range(1, MAX_DIGITS);
				repeat (ndig) text.insert(text.size(), rand_hex_char());
				prev_full = (ndig == MAX_DIGITS);
				if ($urandom_range(0, 11) == 0)
					text.insert(text.size(), 8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 3) == 0) text.insert(text.size(), slhap_pkg::CH_SPACE);
		end
		foreach (text[j]) send_word(text[j], 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic wait_owed_empty();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, one long hold on request
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 8);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			tracker.check_word(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
		end
	end

	// Main sequence
	initial begin
		int start_words;
		bit hold_done, drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines: empty line, non-stack line, lone zero and bare prefix,
		// space skip with odd terminator, full token then wrapped zero, bad prefix
		send_text("");
		send_text("Z@1");
		send_text("@0 0X");
		send_text("@ 0xA,5");
		send_text("@fFFFFFFFFFFFFFFF0");
		send_text("@0xg");
		send_text("@0x0 3");

		start_words = words_sent;
		while (words_sent - start_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
			if (!hold_done && words_sent - start_words > 500) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && words_sent - start_words > 1100) begin
				wait_owed_empty();
				drain_done = 1'b1;
			end
			send_random_line();
		end

		wait_owed_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
